/* hdl/psar_pkg.sv */
// ----------------------------------------------------------------------------
// Parabolic stop and reverse package
// Shared types and constants for the stop and reverse tracker: the candle
// and result beats, the acceleration settings and the register indexes.
// ----------------------------------------------------------------------------
package psar_pkg;

    localparam int IN_BITS    = 32;
    localparam int ACCEL_BITS = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_STEP  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_MAX   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_START = 2'd2;

    localparam logic [ACCEL_BITS-1:0] RST_ACCEL_STEP  = 16'd66;
    localparam logic [ACCEL_BITS-1:0] RST_ACCEL_MAX   = 16'd13107;
    localparam logic [ACCEL_BITS-1:0] RST_ACCEL_START = 16'd1311;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } t_signal;

    typedef struct packed {
        logic [ACCEL_BITS-1:0] step;
        logic [ACCEL_BITS-1:0] max;
        logic [ACCEL_BITS-1:0] start;
    } t_accel_cfg;

    typedef struct packed {
        logic [IN_BITS-1:0] open_price;
        logic [IN_BITS-1:0] high_price;
        logic [IN_BITS-1:0] low_price;
        logic [IN_BITS-1:0] close_price;
    } t_candle;

    typedef struct packed {
        logic [IN_BITS-1:0] stop_value;
        logic               trend_long;
        t_signal            signal_kind;
    } t_result;

endpackage

/* hdl/psar_cfg.sv */
// ----------------------------------------------------------------------------
// Parabolic stop and reverse settings
// Holds the three acceleration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module psar_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [psar_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [psar_pkg::ACCEL_BITS-1:0]   i_cfg_data,
    output psar_pkg::t_accel_cfg              o_cfg
);
    import psar_pkg::*;

    t_accel_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step  <= RST_ACCEL_STEP;
            r_cfg.max   <= RST_ACCEL_MAX;
            r_cfg.start <= RST_ACCEL_START;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACCEL_STEP:  r_cfg.step  <= i_cfg_data;
                CFG_ACCEL_MAX:   r_cfg.max   <= i_cfg_data;
                CFG_ACCEL_START: r_cfg.start <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/psar_core.sv */
// ----------------------------------------------------------------------------
// Parabolic stop and reverse core
// Holds the tracker state and computes one candle's new stop, trend and
// signal; the state is updated when the beat moves into the result register.
// ----------------------------------------------------------------------------
module psar_core #(
    parameter int PRICE_BITS      = 32,
    parameter int ACCEL_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  psar_pkg::t_candle    i_candle,
    input  psar_pkg::t_accel_cfg i_cfg,
    output psar_pkg::t_result    o_result
);
    import psar_pkg::*;

    localparam int PW   = PRICE_BITS;
    localparam int CW   = (PW > IN_BITS) ? PW : IN_BITS;
    localparam int PRW  = PW + ACCEL_BITS;
    localparam int SUMW = PRW + 1;
    localparam logic [PW-1:0] PRICE_MAX = {PW{1'b1}};

    logic [PW-1:0]         r_stop, n_stop;
    logic [PW-1:0]         r_ext, n_ext;
    logic [ACCEL_BITS-1:0] r_accel, n_accel;
    logic                  r_long, n_long;
    logic                  r_first;

    logic [CW-1:0]         w_open_x, w_high_x, w_low_x, w_close_x, w_stop_x;
    logic [PW-1:0]         w_open, w_high, w_low, w_close;
    logic                  w_up;
    logic [PW-1:0]         w_mag;
    logic [PRW-1:0]        w_prod;
    logic [PRW-1:0]        w_step;
    logic [SUMW-1:0]       w_sum_up, w_sum_dn;
    logic [PW-1:0]         w_moved;
    logic [ACCEL_BITS:0]   w_raise_sum;
    logic [ACCEL_BITS-1:0] w_raised;
    t_signal               w_sig;

    assign w_open_x  = CW'(i_candle.open_price);
    assign w_high_x  = CW'(i_candle.high_price);
    assign w_low_x   = CW'(i_candle.low_price);
    assign w_close_x = CW'(i_candle.close_price);
    assign w_open    = w_open_x[PW-1:0];
    assign w_high    = w_high_x[PW-1:0];
    assign w_low     = w_low_x[PW-1:0];
    assign w_close   = w_close_x[PW-1:0];

    // Move the stop towards the extreme by the acceleration times the gap.
    assign w_up     = (r_ext >= r_stop);
    assign w_mag    = w_up ? (r_ext - r_stop) : (r_stop - r_ext);
    assign w_prod   = PRW'(w_mag) * PRW'(r_accel);
    assign w_step   = w_prod >> ACCEL_FRAC_BITS;
    assign w_sum_up = SUMW'(r_stop) + SUMW'(w_step);
    assign w_sum_dn = SUMW'(r_stop) - SUMW'(w_step);

    always_comb begin
        if (w_up) begin
            if (w_sum_up > SUMW'(PRICE_MAX)) begin
                w_moved = PRICE_MAX;
            end else begin
                w_moved = w_sum_up[PW-1:0];
            end
        end else begin
            if (SUMW'(w_step) > SUMW'(r_stop)) begin
                w_moved = '0;
            end else begin
                w_moved = w_sum_dn[PW-1:0];
            end
        end
    end

    assign w_raise_sum = (ACCEL_BITS + 1)'(r_accel) + (ACCEL_BITS + 1)'(i_cfg.step);
    assign w_raised    = (w_raise_sum > (ACCEL_BITS + 1)'(i_cfg.max)) ?
                         i_cfg.max : w_raise_sum[ACCEL_BITS-1:0];

    always_comb begin
        n_stop  = r_stop;
        n_ext   = r_ext;
        n_accel = r_accel;
        n_long  = r_long;
        if (r_first) begin
            n_long  = (w_close > w_open);
            n_stop  = n_long ? w_low : w_high;
            n_ext   = n_long ? w_high : w_low;
            n_accel = i_cfg.start;
        end else begin
            if (r_long && (w_high > r_ext)) begin
                n_ext   = w_high;
                n_accel = w_raised;
            end else if (!r_long && (w_low < r_ext)) begin
                n_ext   = w_low;
                n_accel = w_raised;
            end
            if (r_long && (w_moved > w_low)) begin
                n_long  = 1'b0;
                n_ext   = w_low;
                n_accel = i_cfg.start;
            end else if (!r_long && (w_moved < w_high)) begin
                n_long  = 1'b1;
                n_ext   = w_high;
                n_accel = i_cfg.start;
            end
            n_stop = w_moved;
        end
    end

    always_comb begin
        if (n_long && (w_close > n_stop)) begin
            w_sig = SIG_BUY;
        end else if (!n_long && (w_close < n_stop)) begin
            w_sig = SIG_SELL;
        end else begin
            w_sig = SIG_NONE;
        end
    end

    assign w_stop_x             = CW'(n_stop);
    assign o_result.stop_value  = w_stop_x[IN_BITS-1:0];
    assign o_result.trend_long  = n_long;
    assign o_result.signal_kind = w_sig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop  <= '0;
            r_ext   <= '0;
            r_accel <= '0;
            r_long  <= 1'b1;
            r_first <= 1'b1;
        end else if (i_advance) begin
            r_stop  <= n_stop;
            r_ext   <= n_ext;
            r_accel <= n_accel;
            r_long  <= n_long;
            r_first <= 1'b0;
        end
    end

    // The first-candle flag clears only when a candle is processed.
    a_first_clears_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_first) |-> $past(i_advance))
        else $error("first-candle flag cleared without a beat");

    // Without a beat the tracker state must hold.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_stop) && $stable(r_ext) && $stable(r_accel)
                        && $stable(r_long)))
        else $error("tracker state changed without a beat");

    // The reported trend is the trend that the state keeps.
    a_trend_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |=> (r_long == $past(o_result.trend_long)))
        else $error("stored trend differs from reported trend");

endmodule

/* hdl/parabolic_stop_and_reverse_unit.sv */
// ----------------------------------------------------------------------------
// Parabolic stop and reverse unit
// Tracks a parabolic stop level over a stream of price candles.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries one candle (open, high, low, close) on the valid
// and stall channel; each candle produces exactly one result beat with the
// new stop level, the trend after the candle and a buy, sell or none signal.
// A candle is first captured in an input register; the single multiply of
// the stop update and the compares then run between that register and the
// result register, which loads the result beat once the output is free.
// A new candle can be taken in every cycle unless the output stalls; the
// throughput is one candle per cycle, set by the core's state update loop.
// When the receiver stalls, the result register holds its beat, the input
// register holds the next candle and only then is the input stalled.
// Reset clears the tracker so that the next candle seeds the trend, and
// loads the acceleration registers with their default values. The user must
// write them via the write port only with no candle in flight, not enforced.
// ----------------------------------------------------------------------------
module parabolic_stop_and_reverse_unit #(
    parameter int PRICE_BITS      = 32,
    parameter int ACCEL_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [psar_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [psar_pkg::ACCEL_BITS-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [psar_pkg::IN_BITS-1:0]      i_open_price,
    input  logic [psar_pkg::IN_BITS-1:0]      i_high_price,
    input  logic [psar_pkg::IN_BITS-1:0]      i_low_price,
    input  logic [psar_pkg::IN_BITS-1:0]      i_close_price,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [psar_pkg::IN_BITS-1:0]      o_stop_value,
    output logic                              o_trend_long,
    output logic [1:0]                        o_signal_kind
);
    import psar_pkg::*;

    t_accel_cfg w_cfg;
    t_candle    r_candle;
    logic       r_in_valid;
    t_result    w_result;
    t_result    r_out;
    logic       r_out_valid;
    logic       w_out_free;
    logic       w_advance;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    psar_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    psar_core #(
        .PRICE_BITS      (PRICE_BITS),
        .ACCEL_FRAC_BITS (ACCEL_FRAC_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_candle  (r_candle),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_candle.open_price  <= i_open_price;
            r_candle.high_price  <= i_high_price;
            r_candle.low_price   <= i_low_price;
            r_candle.close_price <= i_close_price;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_stop_value  = r_out.stop_value;
    assign o_trend_long  = r_out.trend_long;
    assign o_signal_kind = r_out.signal_kind;

endmodule
